FILE: hw/rtl/pctc_pkg.sv
// ----------------------------------------------------------------------------
// Prefix code tree coder package
// Shared word formats, opcodes, error codes and fixed widths.
// ----------------------------------------------------------------------------
package pctc_pkg;

  localparam int unsigned SymW   = 8;
  localparam int unsigned CodeW  = 16;
  localparam int unsigned LenW   = 5;
  localparam int unsigned NumSym = 256;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_DECODE = 2'd1,
    OP_ENCODE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_PATH     = 2'd1,
    ERR_SYMBOL   = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_e;

  typedef struct packed {
    op_e             opcode;
    logic [SymW-1:0] tree_byte;
    logic            in_bit;
    logic [SymW-1:0] symbol_in;
  } in_item_t;

  typedef struct packed {
    logic             symbol_valid;
    logic [SymW-1:0]  symbol_out;
    logic [CodeW-1:0] code_bits;
    logic [LenW-1:0]  code_length;
    err_e             error;
  } out_item_t;

  typedef struct packed {
    logic left;
    logic right;
    logic sym;
  } node_we_t;

endpackage

FILE: hw/rtl/pctc_node_store.sv
// ----------------------------------------------------------------------------
// Prefix code tree node store
// Left link, right link and symbol memories with one write and one
// registered read port.
// ----------------------------------------------------------------------------
module pctc_node_store import pctc_pkg::*; #(
  parameter int unsigned NODE_MAX = 256,
  localparam int unsigned NW      = $clog2(NODE_MAX)
) (
  input  logic            clk_i,
  input  node_we_t        we_i,
  input  logic [NW-1:0]   wr_addr_i,
  input  logic [NW-1:0]   wr_left_i,
  input  logic [NW-1:0]   wr_right_i,
  input  logic [SymW-1:0] wr_sym_i,
  input  logic [NW-1:0]   rd_addr_i,
  output logic [NW-1:0]   rd_left_o,
  output logic [NW-1:0]   rd_right_o,
  output logic [SymW-1:0] rd_sym_o
);

  logic [NW-1:0]   left_mem  [NODE_MAX];
  logic [NW-1:0]   right_mem [NODE_MAX];
  logic [SymW-1:0] sym_mem   [NODE_MAX];

  always_ff @(posedge clk_i) begin
    if (we_i.left) begin
      left_mem[wr_addr_i] <= wr_left_i;
    end
    if (we_i.right) begin
      right_mem[wr_addr_i] <= wr_right_i;
    end
    if (we_i.sym) begin
      sym_mem[wr_addr_i] <= wr_sym_i;
    end
    rd_left_o  <= left_mem[rd_addr_i];
    rd_right_o <= right_mem[rd_addr_i];
    rd_sym_o   <= sym_mem[rd_addr_i];
  end

endmodule

FILE: hw/rtl/pctc_code_table.sv
// ----------------------------------------------------------------------------
// Prefix code tree code table
// Code and length per symbol in a memory, with a valid flag per symbol; all
// flags are cleared together by the clear input.
// ----------------------------------------------------------------------------
module pctc_code_table import pctc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             wr_en_i,
  input  logic [SymW-1:0]  wr_sym_i,
  input  logic [LenW-1:0]  wr_len_i,
  input  logic [CodeW-1:0] wr_code_i,
  input  logic [SymW-1:0]  rd_sym_i,
  output logic             rd_valid_o,
  output logic [LenW-1:0]  rd_len_o,
  output logic [CodeW-1:0] rd_code_o
);

  logic [NumSym-1:0]       valid_q;
  logic [LenW+CodeW-1:0]   entry_mem [NumSym];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_o <= 1'b0;
    end else begin
      if (clear_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_sym_i] <= 1'b1;
      end
      rd_valid_o <= valid_q[rd_sym_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_mem[wr_sym_i] <= {wr_len_i, wr_code_i};
    end
    {rd_len_o, rd_code_o} <= entry_mem[rd_sym_i];
  end

endmodule

FILE: hw/rtl/prefix_code_tree_coder.sv
// ----------------------------------------------------------------------------
// Prefix code tree coder
// Loads a prefix code tree in preorder, decodes one bit at a time and
// encodes one symbol at a time.
// ----------------------------------------------------------------------------
// The input channel takes one word per item: a tree byte to load, a coded
// bit to decode or a symbol to encode, chosen by the opcode. The output
// channel returns exactly one result word per item. A small sequencer steps
// the item through the node store and code table, one memory access a cycle,
// and the block is not ready while an item is in flight.
// Encode reads the code table, then returns its entry. Decode reads the node
// and, when it is no leaf, its child. A decode with no complete tree loaded
// returns straight from idle, as does a word with the unused opcode. A
// non-empty tree byte allocates a node, then writes its parent link if any.
// An empty tree byte climbs one step per finished right branch on the path.
// The result sits in an output register; a new item is taken in the cycle
// that the result is taken, so a stalled receiver holds back the input.
// Reset empties the tree and the code table at once; no clearing pass runs.
// ----------------------------------------------------------------------------
module prefix_code_tree_coder import pctc_pkg::*; #(
  parameter int unsigned NODE_MAX  = 256,
  parameter int unsigned MAX_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned DL  = (MAX_DEPTH < 16) ? MAX_DEPTH : 16;
  localparam int unsigned NW  = $clog2(NODE_MAX);
  localparam int unsigned CW  = $clog2(NODE_MAX + 1);
  localparam int unsigned DW  = $clog2(DL + 1);
  localparam int unsigned SIW = $clog2(DL);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLIMB = 7'b0000010,
    S_ALLOC = 7'b0000100,
    S_LINK  = 7'b0001000,
    S_ENC   = 7'b0010000,
    S_DEC1  = 7'b0100000,
    S_DEC2  = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  in_item_t        item_q, item_d;
  out_item_t       out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic [DW-1:0]   depth_q, depth_d;
  logic [DL-1:0]   path_q, path_d;
  logic [CW-1:0]   count_q, count_d;
  logic [NW-1:0]   walk_q, walk_d;
  logic            ready_q, ready_d;
  logic [NW-1:0]   stack_q [DL];
  logic [NW-1:0]   stack_d [DL];
  logic [NW-1:0]   link_addr_q, link_addr_d;
  logic            link_right_q, link_right_d;
  logic [NW-1:0]   link_node_q, link_node_d;

  logic            accept;
  logic            finish;
  logic            clear_tree;
  out_item_t       res;
  logic [DW-1:0]   dm1;
  logic [SIW-1:0]  dm1_idx;
  logic [SIW-1:0]  d_idx;
  logic [NW-1:0]   new_node;
  logic [NW-1:0]   nxt;

  node_we_t        ns_we;
  logic [NW-1:0]   ns_wr_addr;
  logic [NW-1:0]   ns_wr_link;
  logic [SymW-1:0] ns_wr_sym;
  logic [NW-1:0]   ns_rd_addr;
  logic [NW-1:0]   ns_rd_left;
  logic [NW-1:0]   ns_rd_right;
  logic [SymW-1:0] ns_rd_sym;

  logic            ct_wr_en;
  logic            ct_rd_valid;
  logic [LenW-1:0] ct_rd_len;
  logic [CodeW-1:0] ct_rd_code;

  pctc_node_store #(
    .NODE_MAX(NODE_MAX)
  ) u_node_store (
    .clk_i      (clk_i),
    .we_i       (ns_we),
    .wr_addr_i  (ns_wr_addr),
    .wr_left_i  (ns_wr_link),
    .wr_right_i (ns_wr_link),
    .wr_sym_i   (ns_wr_sym),
    .rd_addr_i  (ns_rd_addr),
    .rd_left_o  (ns_rd_left),
    .rd_right_o (ns_rd_right),
    .rd_sym_o   (ns_rd_sym)
  );

  pctc_code_table u_code_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (clear_tree),
    .wr_en_i    (ct_wr_en),
    .wr_sym_i   (item_q.tree_byte),
    .wr_len_i   (LenW'(depth_q)),
    .wr_code_i  (CodeW'(path_q)),
    .rd_sym_i   (in_data_i.symbol_in),
    .rd_valid_o (ct_rd_valid),
    .rd_len_o   (ct_rd_len),
    .rd_code_o  (ct_rd_code)
  );

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign dm1      = DW'(depth_q - DW'(1));
  assign dm1_idx  = dm1[SIW-1:0];
  assign d_idx    = depth_q[SIW-1:0];
  assign new_node = count_q[NW-1:0];
  assign nxt      = item_q.in_bit ? ns_rd_right : ns_rd_left;

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    depth_d      = depth_q;
    path_d       = path_q;
    count_d      = count_q;
    walk_d       = walk_q;
    ready_d      = ready_q;
    stack_d      = stack_q;
    link_addr_d  = link_addr_q;
    link_right_d = link_right_q;
    link_node_d  = link_node_q;
    finish       = 1'b0;
    clear_tree   = 1'b0;
    res          = '0;
    ns_we        = '0;
    ns_wr_addr   = new_node;
    ns_wr_link   = '0;
    ns_wr_sym    = '0;
    ns_rd_addr   = walk_q;
    ct_wr_en     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d = in_data_i;
          unique case (in_data_i.opcode)
            OP_LOAD: begin
              clear_tree = ready_q;
              state_d    = (in_data_i.tree_byte == '0) ? S_CLIMB : S_ALLOC;
            end
            OP_DECODE: begin
              if (!ready_q || count_q == '0) begin
                res.error = ERR_PATH;
                finish    = 1'b1;
              end else begin
                state_d = S_DEC1;
              end
            end
            OP_ENCODE: begin
              state_d = S_ENC;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      S_CLIMB: begin
        if (depth_q != '0 && path_q[dm1_idx]) begin
          depth_d          = dm1;
          path_d[dm1_idx]  = 1'b0;
        end else begin
          if (depth_q == '0) begin
            path_d  = '0;
            ready_d = 1'b1;
          end else begin
            path_d[dm1_idx] = 1'b1;
          end
          finish = 1'b1;
        end
      end
      S_ALLOC: begin
        if (depth_q >= DW'(DL) || count_q >= CW'(NODE_MAX)) begin
          clear_tree = 1'b1;
          res.error  = ERR_OVERFLOW;
          finish     = 1'b1;
        end else begin
          ns_we        = '{left: 1'b1, right: 1'b1, sym: 1'b1};
          ns_wr_sym    = (item_q.tree_byte > 8'd1) ? item_q.tree_byte : '0;
          ct_wr_en     = (item_q.tree_byte > 8'd1);
          count_d      = CW'(count_q + CW'(1));
          stack_d[d_idx] = new_node;
          depth_d      = DW'(depth_q + DW'(1));
          link_addr_d  = stack_q[dm1_idx];
          link_right_d = path_q[dm1_idx];
          link_node_d  = new_node;
          if (depth_q != '0) begin
            state_d = S_LINK;
          end else begin
            finish = 1'b1;
          end
        end
      end
      S_LINK: begin
        ns_we      = '{left: !link_right_q, right: link_right_q, sym: 1'b0};
        ns_wr_addr = link_addr_q;
        ns_wr_link = link_node_q;
        finish     = 1'b1;
      end
      S_ENC: begin
        if (ct_rd_valid) begin
          res.code_bits   = ct_rd_code;
          res.code_length = ct_rd_len;
        end else begin
          res.error = ERR_SYMBOL;
        end
        finish = 1'b1;
      end
      S_DEC1: begin
        if (ns_rd_sym != '0) begin
          res.symbol_valid = 1'b1;
          res.symbol_out   = ns_rd_sym;
          walk_d           = '0;
          finish           = 1'b1;
        end else if (nxt == '0) begin
          res.error = ERR_PATH;
          walk_d    = '0;
          finish    = 1'b1;
        end else begin
          ns_rd_addr = nxt;
          walk_d     = nxt;
          state_d    = S_DEC2;
        end
      end
      S_DEC2: begin
        if (ns_rd_sym != '0) begin
          res.symbol_valid = 1'b1;
          res.symbol_out   = ns_rd_sym;
          walk_d           = '0;
        end
        finish = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (clear_tree) begin
      depth_d = '0;
      path_d  = '0;
      count_d = '0;
      walk_d  = '0;
      ready_d = 1'b0;
    end

    if (finish) begin
      out_d       = res;
      out_valid_d = 1'b1;
      state_d     = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      depth_q     <= '0;
      path_q      <= '0;
      count_q     <= '0;
      walk_q      <= '0;
      ready_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      depth_q     <= depth_d;
      path_q      <= path_d;
      count_q     <= count_d;
      walk_q      <= walk_d;
      ready_q     <= ready_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    out_q        <= out_d;
    stack_q      <= stack_d;
    link_addr_q  <= link_addr_d;
    link_right_q <= link_right_d;
    link_node_q  <= link_node_d;
  end

endmodule
